// ----- sv/ofifo_pkg.sv -----
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared types and codes for the overwriting sample ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofifo_pkg;

    localparam int DATA_W = 32;
    localparam int AMT_W  = 13;
    localparam int FILL_W = 13;

    // Request actions.
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_SKIP  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] sample;
        logic [AMT_W-1:0]  amount;
    } ofifo_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [1:0]        status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } ofifo_rsp_t;

    // One result as issued by the controller; the sample word, if any,
    // joins it in the next cycle from the memory read port.
    typedef struct packed {
        logic              from_mem;
        logic [1:0]        status;
        logic              last;
        logic [FILL_W-1:0] fill_level;
    } ofifo_issue_t;

endpackage

// ----- sv/ofifo_mem.sv -----
// ----------------------------------------------------------------------------
// ofifo_mem
// Sample store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofifo_mem
    import ofifo_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule

// ----- sv/ofifo_outq.sv -----
// ----------------------------------------------------------------------------
// ofifo_outq
// Result stage: joins issued results with read data and buffers two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofifo_outq
    import ofifo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         issue_valid,
    input  ofifo_issue_t issue,
    input  logic [DATA_W-1:0] rd_data,
    output logic         room,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output ofifo_rsp_t   rsp_item
);

    logic         pend_valid_reg;
    ofifo_issue_t pend_reg;
    ofifo_rsp_t   q_reg [2];
    logic         head_reg;
    logic [1:0]   occ_reg;
    logic [1:0]   occ_next;
    logic         pop;
    logic         tail;
    logic [2:0]   level;
    ofifo_rsp_t   push_item;

    assign rsp_valid = (occ_reg != 2'd0);
    assign rsp_item  = q_reg[head_reg];
    assign pop       = rsp_valid && !rsp_stall;

    // Entries held after this edge, not counting a result issued now.
    assign level = 3'(occ_reg) + 3'(pend_valid_reg) - 3'(pop);
    assign room  = (level < 3'd2);

    assign tail = head_reg ^ occ_reg[0];

    always_comb
    begin
        push_item.data_out   = pend_reg.from_mem ? rd_data : '0;
        push_item.status     = pend_reg.status;
        push_item.last       = pend_reg.last;
        push_item.fill_level = pend_reg.fill_level;
        occ_next = occ_reg + 2'(pend_valid_reg) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            head_reg       <= 1'b0;
            occ_reg        <= 2'd0;
        end
        else
        begin
            pend_valid_reg <= issue_valid;
            occ_reg        <= occ_next;
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_valid)
        begin
            pend_reg <= issue;
        end
        if (pend_valid_reg)
        begin
            q_reg[tail] <= push_item;
        end
    end

endmodule

// ----- sv/ofifo_ctrl.sv -----
// ----------------------------------------------------------------------------
// ofifo_ctrl
// Pointer and count keeper; decodes requests and sequences get runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofifo_ctrl
    import ofifo_pkg::*;
#(
    parameter int DEPTH   = 4096,
    parameter int MAX_RUN = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  ofifo_req_t               req_item,
    input  logic                     room,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [DATA_W-1:0]        wr_data,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     issue_valid,
    output ofifo_issue_t             issue
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > AMT_W) ? CW : AMT_W) + 1;
    localparam int RW = $clog2(MAX_RUN + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [RW-1:0]   remain_reg, remain_next;
    logic            accept;
    logic            full;
    logic [XW-1:0]   amount_x;
    logic [XW-1:0]   count_x;
    logic [XW-1:0]   skip_sum;
    logic [XW-1:0]   count_next_x;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign req_stall = !((state_reg == S_IDLE) && room);
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CW'(DEPTH));
    assign amount_x  = XW'(req_item.amount);
    assign count_x   = XW'(count_reg);

    assign wr_addr = wr_ptr_reg;
    assign wr_data = req_item.sample;
    assign rd_addr = rd_ptr_reg;

    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        issue_valid = 1'b0;
        issue.from_mem = 1'b0;
        issue.status   = ST_OK;
        issue.last     = 1'b1;
        skip_sum = XW'(rd_ptr_reg) + amount_x;
        if (skip_sum >= XW'(DEPTH))
        begin
            skip_sum = skip_sum - XW'(DEPTH);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    issue_valid = 1'b1;
                    unique case (req_item.action)
                        ACT_PUT:
                        begin
                            wr_en       = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            if (full)
                            begin
                                rd_ptr_next  = ptr_inc(rd_ptr_reg);
                                issue.status = ST_DROPPED;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_GET:
                        begin
                            if (req_item.amount > AMT_W'(MAX_RUN))
                            begin
                                issue.status = ST_TOO_LONG;
                            end
                            else if (amount_x > count_x)
                            begin
                                issue.status = ST_SHORT;
                            end
                            else if (req_item.amount != '0)
                            begin
                                rd_en          = 1'b1;
                                issue.from_mem = 1'b1;
                                rd_ptr_next    = ptr_inc(rd_ptr_reg);
                                count_next     = count_reg - 1'b1;
                                if (req_item.amount != AMT_W'(1))
                                begin
                                    issue.last  = 1'b0;
                                    remain_next = RW'(req_item.amount - AMT_W'(1));
                                    state_next  = S_RUN;
                                end
                            end
                        end
                        ACT_SKIP:
                        begin
                            if (amount_x > count_x)
                            begin
                                issue.status = ST_SHORT;
                            end
                            else
                            begin
                                rd_ptr_next = skip_sum[PW-1:0];
                                count_next  = CW'(count_x - amount_x);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            count_next  = '0;
                        end
                        default:
                        begin
                            issue_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (room)
                begin
                    issue_valid    = 1'b1;
                    rd_en          = 1'b1;
                    issue.from_mem = 1'b1;
                    rd_ptr_next    = ptr_inc(rd_ptr_reg);
                    count_next     = count_reg - 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == RW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        issue.last = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next_x     = XW'(count_next);
        issue.fill_level = count_next_x[FILL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- sv/overwriting_sample_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// overwriting_sample_ring_fifo
// Path: the first result of a request passes the alignment stage and then
//   the result buffer before it is offered at the output.
// Throughput: one request per cycle while the output is not stalled; a get
//   run of N samples gives N results, and the next request is taken once
//   the last read is issued. The rate is set by the memory's single read port.
// Reset clears pointers, count and result buffer; sample memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A put writes the sample at the write pointer. When the store is full the
// oldest sample is overwritten: the read pointer steps past it and the result
// reports it as dropped. A get is checked against the run limit first, then
// against the stored count; a refused get gives one status result and changes
// nothing. An accepted get reads one sample per cycle from the memory, oldest
// first, and marks the final one. Skip moves the read pointer by the amount
// with one wrap, and clear zeroes both pointers and the count.
//
// Every result is issued by the controller into a register stage that lines
// it up with the memory read data, then lands in a two-entry result buffer.
// The controller only issues when that buffer is sure to have space, so a
// stalled output never loses a transfer and a free one runs back to back.

module overwriting_sample_ring_fifo
    import ofifo_pkg::*;
#(
    parameter int DEPTH   = 4096,
    parameter int MAX_RUN = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  ofifo_req_t req_item,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output ofifo_rsp_t rsp_item
);

    localparam int PW = $clog2(DEPTH);

    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              room;
    logic              issue_valid;
    ofifo_issue_t      issue;

    // Request decode, pointers and the get run sequencer.
    ofifo_ctrl #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_item    (req_item),
        .room        (room),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .issue_valid (issue_valid),
        .issue       (issue)
    );

    // Sample store with registered read data.
    ofifo_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read data alignment and result buffering toward the output.
    ofifo_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue       (issue),
        .rd_data     (rd_data),
        .room        (room),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item)
    );

endmodule

// ----- sv/ofifo_chk.sv -----
// ----------------------------------------------------------------------------
// ofifo_chk
// Port-level checks for the overwriting sample ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ofifo_chk
    import ofifo_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  ofifo_req_t req_item,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  ofifo_rsp_t rsp_item
);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    // A stalled request stays in place until it is transferred.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_item))
        else $error("stalled request changed");

    // A stalled result stays in place until it is transferred.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed");

    // A refused or dropping result is a single, final result with no data.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status != ST_OK) |->
            rsp_item.last && (rsp_item.data_out == '0))
        else $error("status result is not a single empty result");

    // Only the samples inside a get run can be non-final.
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.last |-> rsp_item.status == ST_OK)
        else $error("non-final result with an error status");

    // Overwriting only happens on a full store, which stays full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.status == ST_DROPPED) |->
            rsp_item.fill_level == FILL_FULL)
        else $error("dropped sample reported on a store that is not full");

endmodule

bind overwriting_sample_ring_fifo ofifo_chk #(.DEPTH(DEPTH)) u_chk (.*);
